// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on each rising clock edge while reset is low.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checks a property on each rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- design/plin_pkg.sv -----
// Package with the types and constants of the piecewise linear interpolator.
`timescale 1ns / 1ps
package plin_pkg;
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int VAL_W           = 32;
   localparam int IDX_W           = 6;
   localparam int CNT_W           = 7;
   localparam int REQ_TDATA_W     = 104;
   localparam int STATUS_W        = 2;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_EMPTY       = 2'd1,
      STATUS_NO_INTERVAL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_EMIT
   } state_type;
endpackage

// ----- design/plin_mem.sv -----
// Breakpoint table memory with one write port and one registered read port.
`timescale 1ns / 1ps
module plin_mem import plin_pkg::*; #(
   parameter int DEPTH = TABLE_DEPTH_DEF,
   parameter int AW    = $clog2(TABLE_DEPTH_DEF),
   parameter int EW    = 2 * VAL_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data
);
   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/plin_div.sv -----
// Restoring divider that yields one quotient bit per cycle for the weight.
`timescale 1ns / 1ps
module plin_div import plin_pkg::*; #(
   parameter int QW = FRAC_BITS_DEF + 1,
   parameter int DW = VAL_W + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);
   localparam int RW = DW + 1;
   localparam int CW = $clog2(QW) + 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] den_ff, den_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [RW-1:0] shifted;
   logic          bit_ge;

   always_comb begin
      shifted = (cnt_ff == '0) ? rem_ff : (rem_ff << 1);
      bit_ge  = (shifted >= den_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = RW'(dividend);
         den_in  = RW'(divisor);
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = bit_ge ? (shifted - den_ff) : shifted;
         quo_in = (quo_ff << 1) | QW'(bit_ge);
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- design/piecewise_linear_interpolator.sv -----
// Top level of the piecewise linear interpolator over a breakpoint table.
// A write word gives no result.
// A query answered by an end value skips the table scan and the divider. One that interpolates
// in interval i scans the table up to that interval at one entry per cycle, then runs the
// divider at one quotient bit per cycle.
// Reset clears control state and entry_count; table entries are undefined until written.
`timescale 1ns / 1ps
module piecewise_linear_interpolator import plin_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // entry_index, entry_time, entry_value, query_time, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // result_value
   output logic [VAL_W-1:0]       rsp_tdata,
   // status
   output logic [STATUS_W-1:0]    rsp_tuser,
   input  logic                   csr_we,
   input  logic [CNT_W-1:0]       csr_wdata
);
   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int NB  = $clog2(TABLE_DEPTH + 1);
   localparam int NW  = (NB > CNT_W) ? NB : CNT_W;
   localparam int QW  = FRAC_BITS + 1;
   localparam int DW  = VAL_W + 1;
   localparam int PW  = QW + DW;
   localparam int EW  = 2 * VAL_W;

   logic [IDX_W-1:0]        req_index;
   logic signed [VAL_W-1:0] req_time, req_value, req_query;
   op_type                  req_op;
   logic                    req_accept;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [NW-1:0]           n_eff;
   logic [AW-1:0]           last_idx;
   logic signed [VAL_W-1:0] q_ff, q_in;
   logic signed [VAL_W-1:0] prev_t_ff, prev_t_in;
   logic [VAL_W-1:0]        prev_v_ff, prev_v_in;
   logic [AW-1:0]           cmp_ff, cmp_in;
   logic [VAL_W-1:0]        v0_ff, v0_in, v1_ff, v1_in;
   logic [DW-1:0]           mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic [VAL_W-1:0]        res_ff, res_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]     rsp_user_ff, rsp_user_in;

   logic                    mem_we;
   logic [AW-1:0]           mem_waddr, mem_raddr;
   logic [EW-1:0]           mem_rdata;
   logic signed [VAL_W-1:0] cur_t;
   logic [VAL_W-1:0]        cur_v;
   logic                    hit, zero_width, at_last;
   logic signed [DW-1:0]    dv;
   logic [DW-1:0]           div_num, div_den;
   logic                    div_start, div_done;
   logic [QW-1:0]           quo;
   logic [VAL_W-1:0]        part;
   logic                    rsp_free, rsp_load;

   assign req_index = req_tdata[IDX_W-1:0];
   assign req_time  = signed'(req_tdata[IDX_W +: VAL_W]);
   assign req_value = signed'(req_tdata[IDX_W + VAL_W +: VAL_W]);
   assign req_query = signed'(req_tdata[IDX_W + 2 * VAL_W +: VAL_W]);
   assign req_op    = op_type'(req_tuser[0]);

   assign req_accept = req_tvalid && req_tready;
   assign n_eff      = (NW'(count_ff) > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_ff);
   assign last_idx   = AW'(n_eff - NW'(1));

   assign cur_t      = signed'(mem_rdata[EW-1:VAL_W]);
   assign cur_v      = mem_rdata[VAL_W-1:0];
   assign hit        = (q_ff >= prev_t_ff) && (q_ff <= cur_t);
   assign zero_width = (cur_t == prev_t_ff);
   assign at_last    = (cmp_ff == last_idx);
   assign div_num    = DW'({q_ff[VAL_W-1], q_ff} - {prev_t_ff[VAL_W-1], prev_t_ff});
   assign div_den    = DW'({cur_t[VAL_W-1], cur_t} - {prev_t_ff[VAL_W-1], prev_t_ff});
   assign dv         = signed'({v1_ff[VAL_W-1], v1_ff}) - signed'({v0_ff[VAL_W-1], v0_ff});
   assign part       = prod_ff[FRAC_BITS +: VAL_W];
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign mem_waddr  = AW'(req_index);

   plin_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW),
      .EW    (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data ({req_time, req_value}),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   plin_div #(
      .QW (QW),
      .DW (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_op == OP_QUERY) begin
               state_in = (n_eff == '0) ? ST_EMIT : ST_FIRST;
            end
         end
         ST_FIRST: state_in = ST_LAST;
         ST_LAST: begin
            if (q_ff <= prev_t_ff || q_ff >= cur_t) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = zero_width ? ST_EMIT : ST_DIV;
            end else if (at_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_raddr  = '0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            mem_we     = req_accept && req_op == OP_WRITE &&
                         (32'(req_index) < 32'(TABLE_DEPTH));
         end
         ST_FIRST: mem_raddr = last_idx;
         ST_LAST:  mem_raddr = AW'(1);
         ST_SCAN: begin
            mem_raddr = cmp_ff + AW'(1);
            div_start = hit && !zero_width;
         end
         ST_EMIT:  rsp_load = rsp_free;
         default: begin
            mem_raddr = '0;
         end
      endcase
   end

   always_comb begin
      count_in  = csr_we ? csr_wdata : count_ff;
      q_in      = q_ff;
      prev_t_in = prev_t_ff;
      prev_v_in = prev_v_ff;
      cmp_in    = cmp_ff;
      v0_in     = v0_ff;
      v1_in     = v1_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      res_in    = res_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               q_in = req_query;
            end
            res_in    = '0;
            status_in = (n_eff == '0) ? STATUS_EMPTY : STATUS_OK;
         end
         ST_FIRST: begin
            prev_t_in = cur_t;
            prev_v_in = cur_v;
         end
         ST_LAST: begin
            cmp_in = AW'(1);
            if (q_ff <= prev_t_ff) begin
               res_in = prev_v_ff;
            end else if (q_ff >= cur_t) begin
               res_in = cur_v;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               v0_in  = prev_v_ff;
               v1_in  = cur_v;
               res_in = prev_v_ff;
            end else if (at_last) begin
               status_in = STATUS_NO_INTERVAL;
            end else begin
               prev_t_in = cur_t;
               prev_v_in = cur_v;
               cmp_in    = cmp_ff + AW'(1);
            end
         end
         ST_DIV: begin
            neg_in = dv[DW-1];
            mag_in = dv[DW-1] ? DW'(-dv) : DW'(dv);
         end
         ST_MUL: prod_in = PW'(quo) * PW'(mag_ff);
         ST_SUM: res_in  = neg_ff ? (v0_ff - part) : (v0_ff + part);
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (status_ff == STATUS_OK) ? res_ff : '0;
         rsp_user_in  = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      prev_t_ff   <= prev_t_in;
      prev_v_ff   <= prev_v_in;
      cmp_ff      <= cmp_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

// ----- design/plin_checker.sv -----
// Port checker for the piecewise linear interpolator and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plin_checker import plin_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [0:0]          req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [VAL_W-1:0]    rsp_tdata,
   input logic [STATUS_W-1:0] rsp_tuser
);
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `ASSERT_CLK(a_status_code, clock, reset,
      rsp_tvalid |-> (rsp_tuser == STATUS_OK || rsp_tuser == STATUS_EMPTY ||
                      rsp_tuser == STATUS_NO_INTERVAL))
   `ASSERT_CLK(a_error_zero, clock, reset,
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0)
   `ASSERT_CLK(a_query_busy, clock, reset,
      req_tvalid && req_tready && req_tuser[0] == OP_QUERY |=> !req_tready)
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid)
endmodule

bind piecewise_linear_interpolator plin_checker u_plin_checker (.*);
